// File: rtl/itmf_pkg.sv
package itmf_pkg;

  localparam int MAX_LEN = 32;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [7:0]  CH_CR         = 8'h0D;
  localparam logic [7:0]  CH_LF         = 8'h0A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [5:0]  LIMIT_RESET   = 6'd32;

  typedef enum logic [1:0] {
    CFG_TIMEOUT_TICKS = 2'd0,
    CFG_FRAME_LIMIT   = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SEND
  } back_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
    logic       end_reason;
  } out_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: rtl/idle_timeout_message_framer.sv
// Idle-timeout message framer.
// The input channel (in_valid, in_ready, in_data) carries either a received
// byte (mode 0) or a one-millisecond tick (mode 1). Carriage return and line
// feed bytes are dropped on entry; other items pass through a two-entry queue
// to the message engine, so the input side keeps taking items while a
// message drains, until the queue is full.
// A message ends when the stored byte count reaches frame_limit (taken as
// 1 when zero and as 32 when above 32), or on a tick once the idle count
// reaches timeout_ticks after at least one byte is stored. It then leaves on
// the output channel (out_valid, out_ready, out_data) one byte per transfer;
// each byte is read from the message memory and registered in the read
// state before it is offered. No new item is taken from the queue until the
// last byte is transferred.
// A stalled receiver simply holds the current byte; the queue then fills and
// in_ready drops. Configuration writes (cfg_valid, cfg_index, cfg_data) are
// always taken and must only happen while the block is idle.
// Reset (rst_n low, synchronous) empties the queue and the message, sets
// timeout_ticks to 100 and frame_limit to 32.
module idle_timeout_message_framer
  import itmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timeout_r;
  logic [5:0]  limit_r;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT_TICKS: timeout_r <= cfg_data;
        CFG_FRAME_LIMIT:   limit_r   <= cfg_data[5:0];
        default: begin
          timeout_r <= timeout_r;
        end
      endcase
    end
  end

  itmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  itmf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .frame_limit   (limit_r),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  a_no_pop_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |-> !out_valid)
    else $error("Queue popped while a message byte is offered.");

  a_no_line_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && !cmd.is_tick |-> (cmd.data != CH_CR) && (cmd.data != CH_LF))
    else $error("Line end byte reached the message engine.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.msg_last |=> !out_valid)
    else $error("Output still valid after the last byte of a message.");

endmodule

// File: rtl/itmf_front.sv
module itmf_front
  import itmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              drop;
  logic              push;
  logic              pop;

  assign in_ready  = (cnt_r != QCNT_W'(QDEPTH));
  assign drop      = !in_data.mode && ((in_data.rx_byte == CH_CR) || (in_data.rx_byte == CH_LF));
  assign push      = in_valid && in_ready && !drop;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].is_tick <= in_data.mode;
      q_r[wr_ptr_r].data    <= in_data.rx_byte;
    end
  end

endmodule

// File: rtl/itmf_back.sv
module itmf_back
  import itmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] timeout_ticks,
  input  logic [5:0]  frame_limit,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  logic [7:0]        mem [MAX_LEN];
  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic              recv_r;
  logic [15:0]       idle_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              reason_r;
  out_t              out_r;

  logic              byte_cmd;
  logic              tick_cmd;
  logic              room;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  lim;
  logic              byte_done;
  logic [15:0]       idle_inc;
  logic              tick_done;
  logic              rd_last;
  logic              mem_we;
  logic              run_state;

  assign byte_cmd = cmd_valid && cmd_ready && !cmd.is_tick;
  assign tick_cmd = cmd_valid && cmd_ready && cmd.is_tick && recv_r;
  assign room     = (count_r < CNT_W'(MAX_LEN));
  assign cnt_inc  = room ? count_r + CNT_W'(1) : count_r;

  always_comb begin
    if (frame_limit == 6'd0) begin
      lim = CNT_W'(1);
    end else if (32'(frame_limit) > 32'(MAX_LEN)) begin
      lim = CNT_W'(MAX_LEN);
    end else begin
      lim = CNT_W'(frame_limit);
    end
  end

  assign byte_done = (cnt_inc >= lim);
  assign idle_inc  = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign tick_done = (idle_inc >= timeout_ticks);
  assign rd_last   = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if ((byte_cmd && byte_done) || (tick_cmd && tick_done)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          state_nxt = out_r.msg_last ? ST_RUN : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    run_state = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_RUN:  run_state = 1'b1;
      ST_SEND: out_valid = 1'b1;
      default: begin
        run_state = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign cmd_ready = run_state;
  assign mem_we    = byte_cmd && room;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      count_r  <= '0;
      recv_r   <= 1'b0;
      idle_r   <= '0;
      rd_idx_r <= '0;
      reason_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (byte_cmd) begin
        count_r  <= cnt_inc;
        recv_r   <= 1'b1;
        idle_r   <= '0;
        rd_idx_r <= '0;
        reason_r <= 1'b1;
      end else if (tick_cmd) begin
        idle_r   <= idle_inc;
        rd_idx_r <= '0;
        reason_r <= 1'b0;
      end else if (out_valid && out_ready) begin
        if (out_r.msg_last) begin
          count_r <= '0;
          recv_r  <= 1'b0;
          idle_r  <= '0;
        end else begin
          rd_idx_r <= rd_idx_r + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= cmd.data;
    end
    if (state_r == ST_READ) begin
      out_r.msg_byte   <= mem[rd_idx_r];
      out_r.msg_last   <= rd_last;
      out_r.end_reason <= reason_r;
    end
  end

endmodule
